// ===== rtl/lepe_pkg.sv =====
// ----------------------------------------------------------------------------
// lepe_pkg
// Shared widths, register indexes, effect codes and types for the LED effect
// pixel encoder.
// ----------------------------------------------------------------------------
package lepe_pkg;

	localparam int unsigned MAX_LEDS   = 1024;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned HEAD_W     = 12;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned PHASE_W    = 11;
	localparam int unsigned LEN_W      = 11;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;

	// effect codes
	localparam logic [MODE_W-1:0] MODE_STATIC  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WAVE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GRAD    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd4;

	localparam logic [3:0] LAST_BYTE = 4'd11;

	// reciprocals: x*6554>>16 == x/10 for x < 16384, x*32897>>23 == x/255 for x < 66052
	localparam logic [15:0] RECIP_10  = 16'd6554;
	localparam logic [15:0] RECIP_255 = 16'd32897;

	localparam logic [PHASE_W-1:0] PHASE_WRAP = 11'd1530;

	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic [MODE_W-1:0] mode;
		logic [LEN_W-1:0]  len;
	} cfg_t;

	// packed in wire order: green, red, blue
	typedef struct packed {
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} pixel_t;

	function automatic logic [7:0] pair_code(input logic [1:0] pair);
		logic [7:0] code;
		case (pair)
			2'b00: code = 8'h88;
			2'b01: code = 8'h8e;
			2'b10: code = 8'he8;
			2'b11: code = 8'hee;
			default: code = 8'h88;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/lepe_if.sv =====
// ----------------------------------------------------------------------------
// lepe_if
// Request channel carrying one LED position, and the SPI byte channel.
// ----------------------------------------------------------------------------
interface lepe_pix_if;
	import lepe_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [IDX_W-1:0]          led_index;
	logic signed [HEAD_W-1:0]  head_position;
	logic [LEVEL_W-1:0]        pulse_level;
	logic [PHASE_W-1:0]        cycle_phase;

	modport source(output valid, output led_index, output head_position,
		output pulse_level, output cycle_phase, input ready);
	modport sink(input valid, input led_index, input head_position,
		input pulse_level, input cycle_phase, output ready);
endinterface

interface lepe_spi_if;
	logic       valid;
	logic       ready;
	logic [7:0] spi_byte;
	logic       last_of_led;

	modport source(output valid, output spi_byte, output last_of_led, input ready);
	modport sink(input valid, input spi_byte, input last_of_led, output ready);
endinterface

// ===== rtl/led_effect_pixel_encoder.sv =====
// ----------------------------------------------------------------------------
// led_effect_pixel_encoder
// Per-LED effect colour (static, wave, pulse, gradient, rainbow) encoded as
// twelve WS2812-style SPI bytes, green, red, blue, high bit pair first.
// ----------------------------------------------------------------------------
//  channel    dir   handshake        payload
//  pix_in     in    valid / ready    led_index, head_position, pulse_level,
//                                    cycle_phase
//  spi_out    out   valid / ready    spi_byte, last_of_led
//  cfg        in    cfg_we           cfg_index, cfg_wdata
//
//  One LED request gives twelve bytes at one byte a cycle while spi_out is ready,
//  so the byte serializer sets the sustained request rate.
//  The colour pipeline is seven stages deep; the finished pixel is then loaded
//  into the serializer before its first byte is offered.
//  Requests enter every cycle until a finished pixel waits at the last stage.
//  A stalled output holds a full pipeline; nothing is dropped or repeated.
//  Reset clears valid bits, serializer state and settings (len resets to 1).
// ----------------------------------------------------------------------------
module led_effect_pixel_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	lepe_pix_if.sink                          pix_in,
	lepe_spi_if.source                        spi_out,
	input  logic                              cfg_we,
	input  logic [lepe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lepe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import lepe_pkg::*;

	cfg_t   cfg_q;
	logic   en;
	logic   pipe_valid;
	pixel_t pipe_pix;
	logic   ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red   <= 8'd0;
			cfg_q.green <= 8'd0;
			cfg_q.blue  <= 8'd0;
			cfg_q.mode  <= MODE_STATIC;
			cfg_q.len   <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED:   cfg_q.red   <= cfg_wdata[7:0];
				REG_GREEN: cfg_q.green <= cfg_wdata[7:0];
				REG_BLUE:  cfg_q.blue  <= cfg_wdata[7:0];
				REG_MODE:  cfg_q.mode  <= cfg_wdata[MODE_W-1:0];
				REG_LEN:   cfg_q.len   <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves when its last stage is empty or the serializer takes it
	assign en           = !pipe_valid || ser_ready;
	assign pix_in.ready = en;

	lepe_color_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (pix_in.valid),
		.led_index     (pix_in.led_index),
		.head_position (pix_in.head_position),
		.pulse_level   (pix_in.pulse_level),
		.cycle_phase   (pix_in.cycle_phase),
		.cfg           (cfg_q),
		.out_valid     (pipe_valid),
		.out_pix       (pipe_pix)
	);

	lepe_spi_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pipe_valid),
		.pix       (pipe_pix),
		.pix_ready (ser_ready),
		.spi_out   (spi_out)
	);

endmodule

// ===== rtl/lepe_color_pipe.sv =====
// ----------------------------------------------------------------------------
// lepe_color_pipe
// Seven-stage colour pipeline: effect operands, products, reciprocal scaling
// and a restoring divider for the gradient, two quotient bits a stage.
// ----------------------------------------------------------------------------
module lepe_color_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [lepe_pkg::IDX_W-1:0]     led_index,
	input  logic signed [lepe_pkg::HEAD_W-1:0] head_position,
	input  logic [lepe_pkg::LEVEL_W-1:0]   pulse_level,
	input  logic [lepe_pkg::PHASE_W-1:0]   cycle_phase,
	input  lepe_pkg::cfg_t                 cfg,
	output logic                           out_valid,
	output lepe_pkg::pixel_t               out_pix
);
	import lepe_pkg::*;

	// component index: 2 red, 1 green, 0 blue
	typedef logic [2:0][7:0] comp3_t;

	function automatic logic [21:0] div2(input logic [19:0] rem, input logic [11:0] den,
		input int hi);
		logic [19:0] r;
		logic [19:0] t0;
		logic [19:0] t1;
		logic [1:0]  q;
		r  = rem;
		q  = 2'b00;
		t0 = 20'(den) << hi;
		if (r >= t0) begin
			r    = r - t0;
			q[1] = 1'b1;
		end
		t1 = 20'(den) << (hi - 1);
		if (r >= t1) begin
			r    = r - t1;
			q[0] = 1'b1;
		end
		return {r, q};
	endfunction

	// ---- stage 0 combinational: distance, clamps, phase wrap
	logic [12:0]        diff;
	logic [11:0]        span;
	logic [3:0]         k_d;
	logic [LEN_W-1:0]   len_d;
	logic [LEN_W-1:0]   i_d;
	logic [PHASE_W-1:0] p_d;

	always_comb begin
		diff = {3'b000, led_index} - {head_position[HEAD_W-1], head_position};
		span = diff[12] ? 12'(-diff) : diff[11:0];
		if (span == 12'd0)
			k_d = 4'd10;
		else if (span <= 12'd8)
			k_d = 4'd10 - span[3:0];
		else
			k_d = 4'd1;

		if (cfg.len == '0)
			len_d = LEN_W'(1);
		else if (cfg.len > LEN_W'(MAX_LEDS))
			len_d = LEN_W'(MAX_LEDS);
		else
			len_d = cfg.len;

		i_d = ({1'b0, led_index} > len_d) ? len_d : {1'b0, led_index};
		p_d = (cycle_phase >= PHASE_WRAP) ? cycle_phase - PHASE_WRAP : cycle_phase;
	end

	// ---- stage 1
	logic               v_s1;
	logic [MODE_W-1:0]  mode_s1;
	comp3_t             c_s1;
	logic [3:0]         k_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [LEN_W-1:0]   i_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [PHASE_W-1:0] p_s1;

	// ---- stage 2
	logic               v_s2;
	logic [MODE_W-1:0]  mode_s2;
	comp3_t             c_s2;
	logic [2:0][15:0]   m_s2;
	logic [2:0][18:0]   ga_s2;
	logic [2:0][18:0]   gb_s2;
	logic [LEN_W-1:0]   len_s2;
	logic [2:0]         seg_s2;
	logic [PHASE_W-1:0] p_s2;

	// ---- stage 3
	logic               v_s3;
	logic [MODE_W-1:0]  mode_s3;
	comp3_t             c_s3;
	logic [2:0][31:0]   recip_s3;
	logic [2:0][19:0]   n_s3;
	logic [11:0]        d_s3;
	logic [2:0]         seg_s3;
	logic [7:0]         s_s3;

	// ---- stages 4..7
	logic               v_s4, v_s5, v_s6, v_s7;
	logic [MODE_W-1:0]  mode_s4, mode_s5, mode_s6, mode_s7;
	comp3_t             fix_s4, fix_s5, fix_s6, fix_s7;
	comp3_t             q_s4, q_s5, q_s6, q_s7;
	logic [2:0][19:0]   rem_s4, rem_s5, rem_s6;
	logic [11:0]        d_s4, d_s5, d_s6;

	logic [7:0]         mul_b;
	logic [2:0]         seg_d;
	logic [15:0]        recip_k;
	comp3_t             rb;
	comp3_t             fix_d;
	logic [2:0][21:0]   dv4, dv5, dv6, dv7;

	always_comb begin
		mul_b = (mode_s1 == MODE_WAVE) ? {4'b0000, k_s1} : level_s1;
		if (p_s1 >= 11'd1275)
			seg_d = 3'd5;
		else if (p_s1 >= 11'd1020)
			seg_d = 3'd4;
		else if (p_s1 >= 11'd765)
			seg_d = 3'd3;
		else if (p_s1 >= 11'd510)
			seg_d = 3'd2;
		else if (p_s1 >= 11'd255)
			seg_d = 3'd1;
		else
			seg_d = 3'd0;
		recip_k = (mode_s2 == MODE_WAVE) ? RECIP_10 : RECIP_255;
	end

	// rainbow ramps
	always_comb begin
		case (seg_s3)
			3'd0: rb = {8'd255, s_s3, 8'd0};
			3'd1: rb = {8'd255 - s_s3, 8'd255, 8'd0};
			3'd2: rb = {8'd0, 8'd255, s_s3};
			3'd3: rb = {8'd0, 8'd255 - s_s3, 8'd255};
			3'd4: rb = {s_s3, 8'd0, 8'd255};
			default: rb = {8'd255, 8'd0, 8'd255 - s_s3};
		endcase
		for (int j = 0; j < 3; j++) begin
			case (mode_s3)
				MODE_WAVE:    fix_d[j] = recip_s3[j][23:16];
				MODE_PULSE:   fix_d[j] = recip_s3[j][30:23];
				MODE_RAINBOW: fix_d[j] = rb[j];
				default:      fix_d[j] = c_s3[j];
			endcase
			dv4[j] = div2(n_s3[j], d_s3, 7);
			dv5[j] = div2(rem_s4[j], d_s4, 5);
			dv6[j] = div2(rem_s5[j], d_s5, 3);
			dv7[j] = div2(rem_s6[j], d_s6, 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= cfg.mode;
			c_s1     <= {cfg.red, cfg.green, cfg.blue};
			k_s1     <= k_d;
			level_s1 <= pulse_level;
			i_s1     <= i_d;
			len_s1   <= len_d;
			p_s1     <= p_d;

			mode_s2 <= mode_s1;
			c_s2    <= c_s1;
			len_s2  <= len_s1;
			seg_s2  <= seg_d;
			p_s2    <= p_s1;
			for (int j = 0; j < 3; j++) begin
				m_s2[j]  <= 16'(c_s1[j]) * 16'(mul_b);
				ga_s2[j] <= 19'(c_s1[j]) * 19'(len_s1 - i_s1);
				gb_s2[j] <= 19'(8'd255 - c_s1[j]) * 19'(i_s1);
			end

			mode_s3 <= mode_s2;
			c_s3    <= c_s2;
			d_s3    <= {len_s2, 1'b0};
			seg_s3  <= seg_s2;
			s_s3    <= 8'(p_s2 - (11'({seg_s2, 8'h00}) - 11'(seg_s2)));
			for (int j = 0; j < 3; j++) begin
				recip_s3[j] <= 32'(m_s2[j]) * 32'(recip_k);
				n_s3[j]     <= ((20'(ga_s2[j]) + 20'(gb_s2[j])) << 1) + 20'(len_s2);
			end

			mode_s4 <= mode_s3;
			fix_s4  <= fix_d;
			d_s4    <= d_s3;
			mode_s5 <= mode_s4;
			fix_s5  <= fix_s4;
			d_s5    <= d_s4;
			mode_s6 <= mode_s5;
			fix_s6  <= fix_s5;
			d_s6    <= d_s5;
			mode_s7 <= mode_s6;
			fix_s7  <= fix_s6;
			for (int j = 0; j < 3; j++) begin
				rem_s4[j] <= dv4[j][21:2];
				q_s4[j]   <= {6'b000000, dv4[j][1:0]};
				rem_s5[j] <= dv5[j][21:2];
				q_s5[j]   <= {q_s4[j][5:0], dv5[j][1:0]};
				rem_s6[j] <= dv6[j][21:2];
				q_s6[j]   <= {q_s5[j][5:0], dv6[j][1:0]};
				q_s7[j]   <= {q_s6[j][5:0], dv7[j][1:0]};
			end
		end
	end

	assign out_valid     = v_s7;
	assign out_pix.red   = (mode_s7 == MODE_GRAD) ? q_s7[2] : fix_s7[2];
	assign out_pix.green = (mode_s7 == MODE_GRAD) ? q_s7[1] : fix_s7[1];
	assign out_pix.blue  = (mode_s7 == MODE_GRAD) ? q_s7[0] : fix_s7[0];

endmodule

// ===== rtl/lepe_spi_ser.sv =====
// ----------------------------------------------------------------------------
// lepe_spi_ser
// Holds one pixel and shifts it out as twelve encoded SPI bytes, two colour
// bits per byte, taking the next pixel in the cycle its last byte leaves.
// ----------------------------------------------------------------------------
module lepe_spi_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	input  lepe_pkg::pixel_t   pix,
	output logic               pix_ready,
	lepe_spi_if.source         spi_out
);
	import lepe_pkg::*;

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [23:0] sh_q;
	logic        load;
	logic        take;

	assign take      = busy_q && spi_out.ready;
	assign pix_ready = !busy_q || (spi_out.ready && cnt_q == LAST_BYTE);
	assign load      = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd0;
		end else if (take) begin
			if (cnt_q == LAST_BYTE)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			sh_q <= pix;
		else if (take)
			sh_q <= {sh_q[21:0], 2'b00};
	end

	assign spi_out.valid       = busy_q;
	assign spi_out.spi_byte    = pair_code(sh_q[23:22]);
	assign spi_out.last_of_led = (cnt_q == LAST_BYTE);

endmodule

// ===== tb/sv/pixel_byte_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_byte_checker
// Watches the LED request channel and the register port, works out each
// LED's effect colour and its twelve SPI symbols, and compares them in order
// with the bytes taken from the SPI channel.
// ----------------------------------------------------------------------------
module pixel_byte_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	lepe_pix_if                               pix,
	lepe_spi_if                               spi,
	input  logic                              cfg_we,
	input  logic [lepe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lepe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                                fail_count,
	output int                                bytes_outstanding,
	output int                                bytes_checked
);
	import lepe_pkg::*;

	localparam logic [7:0] SYM_00 = 8'h88;
	localparam logic [7:0] SYM_01 = 8'h8e;
	localparam logic [7:0] SYM_10 = 8'he8;
	localparam logic [7:0] SYM_11 = 8'hee;
	localparam int         MISMATCH_REPORTS = 10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} spi_symbol_t;

	cfg_t        effect_cfg;
	spi_symbol_t symbols_due[$];
	spi_symbol_t want;
	spi_symbol_t got;
	pixel_t      color;
	logic [1:0]  pair;
	int          mismatches;
	int          seen;

	function automatic pixel_t effect_pixel(input cfg_t cfg, input logic [IDX_W-1:0] led,
		input logic signed [HEAD_W-1:0] head, input logic [LEVEL_W-1:0] level,
		input logic [PHASE_W-1:0] phase);
		int base [3];
		int shade [3];
		int span;
		int len;
		int pos;
		int wrapped;
		int step;
		pixel_t px;
		base[0] = int'(cfg.red);
		base[1] = int'(cfg.green);
		base[2] = int'(cfg.blue);
		shade = base;
		case (cfg.mode)
			MODE_WAVE: begin
				span = int'(led) - int'(head);
				if (span < 0)
					span = -span;
				foreach (shade[j]) begin
					if (span == 0)
						shade[j] = base[j];
					else if (span <= 8)
						shade[j] = base[j] * (10 - span) / 10;
					else
						shade[j] = base[j] / 10;
				end
			end
			MODE_PULSE: begin
				foreach (shade[j])
					shade[j] = base[j] * int'(level) / 255;
			end
			MODE_GRAD: begin
				len = int'(cfg.len);
				if (len == 0)
					len = 1;
				if (len > int'(MAX_LEDS))
					len = int'(MAX_LEDS);
				pos = (int'(led) > len) ? len : int'(led);
				// blend toward the inverse colour, round half up
				foreach (shade[j])
					shade[j] = (2 * (base[j] * (len - pos) + (255 - base[j]) * pos) + len)
						/ (2 * len);
			end
			MODE_RAINBOW: begin
				wrapped = int'(phase) % int'(PHASE_WRAP);
				step = wrapped % 255;
				case (wrapped / 255)
					0:       shade = '{255, step, 0};
					1:       shade = '{255 - step, 255, 0};
					2:       shade = '{0, 255, step};
					3:       shade = '{0, 255 - step, 255};
					4:       shade = '{step, 0, 255};
					default: shade = '{255, 0, 255 - step};
				endcase
			end
			default: ; // static, and the spare codes act as static
		endcase
		px.red   = shade[0][7:0];
		px.green = shade[1][7:0];
		px.blue  = shade[2][7:0];
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_cfg <= '{red: 8'd0, green: 8'd0, blue: 8'd0, mode: MODE_STATIC, len: 11'd1};
			symbols_due.delete();
			mismatches = 0;
			seen = 0;
			fail_count <= 0;
			bytes_outstanding <= 0;
			bytes_checked <= 0;
		end else begin
			if (spi.valid && spi.ready) begin
				got.code = spi.spi_byte;
				got.last = spi.last_of_led;
				seen++;
				if (symbols_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_REPORTS)
						$display("%0t: SPI byte %02h last=%0b with no request pending",
							$time, got.code, got.last);
				end else begin
					want = symbols_due.pop_front();
					if (got.code !== want.code || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= MISMATCH_REPORTS)
							$display("%0t: SPI byte mismatch: expected %02h last=%0b, got %02h last=%0b",
								$time, want.code, want.last, got.code, got.last);
					end
				end
			end

			// bytes pass the pipeline first, so a new request never feeds this compare
			if (pix.valid && pix.ready) begin
				color = effect_pixel(effect_cfg, pix.led_index, pix.head_position,
					pix.pulse_level, pix.cycle_phase);
				for (int k = 0; k < 12; k++) begin
					pair = color[23 - 2 * k -: 2];
					case (pair)
						2'b00:   want.code = SYM_00;
						2'b01:   want.code = SYM_01;
						2'b10:   want.code = SYM_10;
						default: want.code = SYM_11;
					endcase
					want.last = (k == int'(LAST_BYTE));
					symbols_due.push_back(want);
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_RED:   effect_cfg.red   <= cfg_wdata[7:0];
					REG_GREEN: effect_cfg.green <= cfg_wdata[7:0];
					REG_BLUE:  effect_cfg.blue  <= cfg_wdata[7:0];
					REG_MODE:  effect_cfg.mode  <= cfg_wdata[MODE_W-1:0];
					REG_LEN:   effect_cfg.len   <= cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end

			fail_count <= mismatches;
			bytes_outstanding <= symbols_due.size();
			bytes_checked <= seen;
		end
	end

endmodule

// ===== tb/sv/led_effect_pixel_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_effect_pixel_encoder_tb
// Drives LED requests and register settings into the pixel encoder with
// random gaps and output stalls; pixel_byte_checker predicts and compares
// every SPI byte. Directed corner cases first, then random effect phases.
// ----------------------------------------------------------------------------
module led_effect_pixel_encoder_tb;
	import lepe_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
	localparam int PIPE_SETTLE  = 16;
	localparam int PHASES       = 16;
	localparam int PER_PHASE    = 27;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    bytes_outstanding;
	int                    bytes_checked;
	int                    pixels_sent;
	int                    settings_used;
	int                    stall_left;
	bit                    pace_on;

	lepe_pix_if pix_ch();
	lepe_spi_if spi_ch();

	led_effect_pixel_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_ch),
		.spi_out   (spi_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pixel_byte_checker chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.pix               (pix_ch),
		.spi               (spi_ch),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.fail_count        (fail_count),
		.bytes_outstanding (bytes_outstanding),
		.bytes_checked     (bytes_checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_color();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return 8'd0;
		if (roll < 30)
			return 8'd255;
		return 8'($urandom);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	// unused upper data bits carry random junk
	task automatic set_effect(input logic [7:0] red, input logic [7:0] green,
		input logic [7:0] blue, input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len);
		write_reg(REG_RED, {3'($urandom), red});
		write_reg(REG_GREEN, {3'($urandom), green});
		write_reg(REG_BLUE, {3'($urandom), blue});
		write_reg(REG_MODE, {8'($urandom), mode});
		write_reg(REG_LEN, len);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_pixel(input logic [IDX_W-1:0] led, input logic signed [HEAD_W-1:0] head,
		input logic [LEVEL_W-1:0] level, input logic [PHASE_W-1:0] phase);
		int gap;
		gap = pace_on ? pick_gap() : 0;
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.led_index <= led;
		pix_ch.head_position <= head;
		pix_ch.pulse_level <= level;
		pix_ch.cycle_phase <= phase;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		pixels_sent++;
	endtask

	// block idle: no request in flight, every byte out, pipeline drained
	task automatic settle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (bytes_outstanding != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	initial begin
		spi_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				spi_ch.ready <= 1'b0;
				stall_left--;
			end else if (!pace_on) begin
				spi_ch.ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				spi_ch.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RED;
		cfg_wdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.led_index = '0;
		pix_ch.head_position = '0;
		pix_ch.pulse_level = '0;
		pix_ch.cycle_phase = '0;
		pace_on = 1'b1;
		pixels_sent = 0;
		settings_used = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: static black
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd0);
		settle();

		// colors chosen so every bit pair shows up in each position
		set_effect(8'he4, 8'h1b, 8'hff, MODE_STATIC, 11'd1);
		send_pixel(10'd1023, -12'sd2048, 8'd255, 11'd2047);
		settle();
		set_effect(8'h5a, 8'ha5, 8'h3c, MODE_SPARE_LO, 11'd7);
		send_pixel(10'd512, 12'sd2047, 8'd77, 11'd900);
		settle();
		set_effect(8'h81, 8'h7e, 8'h00, MODE_SPARE_HI, 11'd1024);
		send_pixel(10'd3, 12'sd3, 8'd1, 11'd1530);
		settle();

		// wave: head hit, distances 1 and 8, just past the ramp, off-strip head
		set_effect(8'd255, 8'd128, 8'd7, MODE_WAVE, 11'd1024);
		send_pixel(10'd5, 12'sd5, 8'd0, 11'd0);
		send_pixel(10'd6, 12'sd5, 8'd0, 11'd0);
		send_pixel(10'd13, 12'sd5, 8'd0, 11'd0);
		send_pixel(10'd14, 12'sd5, 8'd0, 11'd0);
		send_pixel(10'd0, -12'sd10, 8'd0, 11'd0);
		send_pixel(10'd1023, -12'sd2048, 8'd0, 11'd0);
		settle();

		set_effect(8'd255, 8'd1, 8'd200, MODE_PULSE, 11'd1);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd0);
		send_pixel(10'd0, 12'sd0, 8'd255, 11'd0);
		send_pixel(10'd0, 12'sd0, 8'd128, 11'd0);
		settle();

		// gradient: zero length taken as one, oversize length clamped, LED past the end
		set_effect(8'd0, 8'd255, 8'd100, MODE_GRAD, 11'd0);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd0);
		send_pixel(10'd5, 12'sd0, 8'd0, 11'd0);
		settle();
		set_effect(8'd0, 8'd255, 8'd100, MODE_GRAD, 11'd2047);
		send_pixel(10'd1023, 12'sd0, 8'd0, 11'd0);
		settle();
		set_effect(8'd0, 8'd255, 8'd100, MODE_GRAD, 11'd10);
		send_pixel(10'd11, 12'sd0, 8'd0, 11'd0);
		send_pixel(10'd3, 12'sd0, 8'd0, 11'd0);
		settle();

		// rainbow: segment edges and phase wrap
		set_effect(8'd9, 8'd9, 8'd9, MODE_RAINBOW, 11'd1);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd0);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd254);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd255);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd1529);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd1530);
		send_pixel(10'd0, 12'sd0, 8'd0, 11'd2047);
		settle();

		for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
			logic [MODE_W-1:0] mode;
			logic [LEN_W-1:0]  len;
			int roll;
			int led_v;
			int head_v;
			int level_v;
			int phase_v;
			case (phase_no % 8)
				0:       mode = MODE_WAVE;
				1:       mode = MODE_GRAD;
				2:       mode = MODE_RAINBOW;
				3:       mode = MODE_PULSE;
				4:       mode = MODE_STATIC;
				5:       mode = MODE_SPARE_LO;
				6:       mode = MODE_SPARE_MID;
				default: mode = MODE_SPARE_HI;
			endcase
			case ($urandom_range(0, 7))
				0:       len = 11'd0;
				1:       len = 11'd1;
				2:       len = 11'd1024;
				3:       len = 11'd2047;
				4:       len = 11'd1025;
				5:       len = 11'($urandom_range(1, 16));
				default: len = 11'($urandom_range(1, 1024));
			endcase
			pace_on <= (phase_no % 4 != 2);
			set_effect(pick_color(), pick_color(), pick_color(), mode, len);
			repeat (PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					led_v = $urandom_range(0, 1) ? 1023 : 0;
				else if (roll < 40 && mode == MODE_GRAD)
					led_v = int'(len) + int'($urandom_range(0, 6)) - 3;
				else
					led_v = $urandom_range(0, 1023);
				if (led_v < 0)
					led_v = 0;
				if (led_v > 1023)
					led_v = 1023;

				roll = $urandom_range(0, 99);
				if (roll < 55 && mode == MODE_WAVE)
					head_v = led_v + int'($urandom_range(0, 22)) - 11;
				else if (roll < 65)
					head_v = $urandom_range(0, 1) ? 1034 : -10;
				else if (roll < 72)
					head_v = $urandom_range(0, 1) ? 2047 : -2048;
				else
					head_v = $urandom_range(0, 4095);

				roll = $urandom_range(0, 99);
				if (roll < 10)
					level_v = $urandom_range(0, 1) ? 255 : 0;
				else
					level_v = $urandom_range(0, 255);

				roll = $urandom_range(0, 99);
				if (roll < 25) begin
					phase_v = int'($urandom_range(0, 6)) * 255 + int'($urandom_range(0, 2)) - 1;
					if (phase_v < 0)
						phase_v = 0;
				end else begin
					phase_v = $urandom_range(0, 2047);
				end

				send_pixel(10'(led_v), 12'(head_v), 8'(level_v), 11'(phase_v));
			end
			settle();
		end

		$display("Covered %0d LED requests over %0d register settings: all eight mode codes,",
			pixels_sent, settings_used);
		$display("strip lengths 0 to 2047, off-strip heads, wrapped phases; %0d SPI bytes checked.",
			bytes_checked);
		if (fail_count == 0 && bytes_outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lepe_pkg.sv
rtl/lepe_if.sv
rtl/lepe_color_pipe.sv
rtl/lepe_spi_ser.sv
rtl/led_effect_pixel_encoder.sv
tb/sv/pixel_byte_checker.sv
tb/sv/led_effect_pixel_encoder_tb.sv
